@@ hw/rtl/lrupin_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupin_pkg: shared types and constants for the pinned LRU sound cache
// Item structs for the request and response channels, field widths,
// parameter defaults and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupin_pkg;

  localparam int KEY_W  = 16;
  localparam int BUSY_W = 8;
  localparam int CHAN_W = 4;
  localparam int SLOT_W = 4;
  localparam int CAP_W  = 5;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_CHANNELS = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic        [KEY_W-1:0]  sound_key;
    logic        [BUSY_W-1:0] busy_channels;
    logic signed [CHAN_W-1:0] assigned_channel;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              no_victim;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lru_cache_with_pinned_entries.sv @@
// ----------------------------------------------------------------------------
// lru_cache_with_pinned_entries: LRU sound-key cache with channel pinning
// Looks up a sound key, promotes it on a hit, inserts it on a miss and
// evicts the oldest entry not owned by a busy output channel when full.
// ----------------------------------------------------------------------------
// Sequencing: an accepted request scans every entry of the key/rank memory
//   through its one read port, then retires into the response register; a new
//   request is taken only after the previous one has retired, back in idle.
// Reset: clears the entry valid bits, entry count, channel owners, pending
//   rank update and the response valid flag; capacity returns to 16. The
//   key/rank memory is not cleared: an entry's contents count only when it is valid.
`default_nettype none

module lru_cache_with_pinned_entries #(
  parameter int ENTRIES  = lrupin_pkg::DEF_ENTRIES,
  parameter int CHANNELS = lrupin_pkg::DEF_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire lrupin_pkg::req_t              req,
  // response channel
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output lrupin_pkg::rsp_t                   rsp,
  // capacity register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lrupin_pkg::CAP_W-1:0]  cfg_data
);

  localparam int KEY_W  = lrupin_pkg::KEY_W;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > lrupin_pkg::CAP_W) ? CNT_W : lrupin_pkg::CAP_W;
  localparam int MEM_W  = KEY_W + IDX_W;
  // Only channels with a busy bit can ever pin an entry.
  localparam int NOWN   = (CHANNELS < lrupin_pkg::BUSY_W) ? CHANNELS : lrupin_pkg::BUSY_W;
  localparam int OWN_W  = (NOWN > 1) ? $clog2(NOWN) : 1;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  lrupin_pkg::state_t state, state_next;

  logic [lrupin_pkg::CAP_W-1:0] cap_q;
  logic [ENTRIES-1:0]           valid;
  logic [CNT_W-1:0]             count;
  logic                         own_v [NOWN];
  logic [KEY_W-1:0]             own_k [NOWN];

  lrupin_pkg::req_t             req_q;

  // Deferred promote of the previous item; applied as each entry is read.
  logic                         pend_v;
  logic [IDX_W-1:0]             pend_slot;
  logic [IDX_W:0]               pend_below;
  logic [KEY_W-1:0]             pend_key;

  // Scan pipeline
  logic [IDX_W:0]               scan_cnt;
  logic                         eval_vld;
  logic [IDX_W-1:0]             eval_idx;

  // Scan results
  logic                         hit_f;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             hit_rank;
  logic                         vic_f;
  logic [IDX_W-1:0]             vic_idx;
  logic [IDX_W-1:0]             vic_rank;
  logic [KEY_W-1:0]             vic_key;
  logic                         free_f;
  logic [IDX_W-1:0]             free_idx;

  // Handshake and sequencing strobes
  logic                         accept;
  logic                         rd_en;
  logic                         scan_last;
  logic                         load;
  logic                         taken;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign taken     = rsp_valid && !rsp_stall;
  assign scan_last = (scan_cnt == (IDX_W + 1)'(ENTRIES));

  // --------------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      lrupin_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = lrupin_pkg::ST_SCAN;
        end
      end
      lrupin_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = lrupin_pkg::ST_DONE;
        end
      end
      lrupin_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = lrupin_pkg::ST_IDLE;
        end
      end
      default: state_next = lrupin_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    load      = 1'b0;
    unique case (state)
      lrupin_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      lrupin_pkg::ST_SCAN: begin
        rd_en = !scan_last;
      end
      lrupin_pkg::ST_DONE: begin
        // Retire into the response register once it is free or draining.
        load = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Key / rank memory: {key, rank} per entry
  // --------------------------------------------------------------------------
  logic [MEM_W-1:0] rd_data;
  logic [MEM_W-1:0] wr_data;
  logic             ram_we;

  lrupin_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (eval_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Per-entry evaluation: apply the pending promote, then test the entry
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0] ent_key;
  logic [IDX_W-1:0] ent_rank;
  logic             ent_valid;
  logic             ent_pinned;

  always_comb begin
    ent_key   = rd_data[MEM_W-1:IDX_W];
    ent_rank  = rd_data[IDX_W-1:0];
    ent_valid = valid[eval_idx];
    if (pend_v) begin
      if (eval_idx == pend_slot) begin
        ent_key  = pend_key;
        ent_rank = '0;
      end else if (ent_valid && ({1'b0, ent_rank} < pend_below)) begin
        ent_rank = ent_rank + IDX_W'(1);
      end
    end
  end

  // Write back only when there is something to fold in.
  assign ram_we  = eval_vld && pend_v;
  assign wr_data = {ent_key, ent_rank};

  // Pinned when the key owns any channel that is still playing.
  always_comb begin
    ent_pinned = 1'b0;
    for (int c = 0; c < NOWN; c++) begin
      if (req_q.busy_channels[c] && own_v[c] && (own_k[c] == ent_key)) begin
        ent_pinned = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Retire decision
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic             full;
  logic             do_store;
  logic [IDX_W-1:0] store_idx;
  logic [IDX_W:0]   store_below;
  logic             own_ok;
  logic [IDX_W+lrupin_pkg::SLOT_W-1:0] slot_wide;
  lrupin_pkg::rsp_t rsp_next;

  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    full = (CMP_W'(count) >= cap_eff);
  end

  always_comb begin
    rsp_next    = '0;
    do_store    = 1'b0;
    store_idx   = '0;
    store_below = '0;
    priority if (hit_f) begin
      rsp_next.hit = 1'b1;
      do_store     = 1'b1;
      store_idx    = hit_idx;
      store_below  = {1'b0, hit_rank};
    end else if (full) begin
      if (vic_f) begin
        rsp_next.evicted     = 1'b1;
        rsp_next.evicted_key = vic_key;
        do_store             = 1'b1;
        store_idx            = vic_idx;
        store_below          = {1'b0, vic_rank};
      end else begin
        rsp_next.no_victim = 1'b1;
      end
    end else begin
      if (free_f) begin
        do_store    = 1'b1;
        store_idx   = free_idx;
        // Every valid entry ages on an insert.
        store_below = (IDX_W + 1)'(ENTRIES);
      end else begin
        rsp_next.no_victim = 1'b1;
      end
    end
    slot_wide     = {{lrupin_pkg::SLOT_W{1'b0}}, store_idx};
    rsp_next.slot = slot_wide[lrupin_pkg::SLOT_W-1:0];
    own_ok = !req_q.assigned_channel[lrupin_pkg::CHAN_W-1] &&
             (int'(req_q.assigned_channel[lrupin_pkg::CHAN_W-2:0]) < NOWN);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrupin_pkg::ST_IDLE;
      cap_q     <= lrupin_pkg::CAP_RESET;
      valid     <= '0;
      count     <= '0;
      pend_v    <= 1'b0;
      eval_vld  <= 1'b0;
      rsp_valid <= 1'b0;
      scan_cnt  <= '0;
      hit_f     <= 1'b0;
      vic_f     <= 1'b0;
      free_f    <= 1'b0;
      for (int c = 0; c < NOWN; c++) begin
        own_v[c] <= 1'b0;
      end
    end else begin
      state    <= state_next;
      eval_vld <= rd_en;

      if (cfg_valid && cfg_ready) begin
        cap_q <= cfg_data;
      end

      // Start a new scan.
      if (accept) begin
        scan_cnt <= '0;
        hit_f    <= 1'b0;
        vic_f    <= 1'b0;
        free_f   <= 1'b0;
      end else if (rd_en) begin
        scan_cnt <= scan_cnt + (IDX_W + 1)'(1);
      end

      // Fold in the entry read last cycle.
      if (eval_vld) begin
        if (ent_valid && (ent_key == req_q.sound_key) && !hit_f) begin
          hit_f <= 1'b1;
        end
        if (ent_valid && !ent_pinned && (!vic_f || (ent_rank > vic_rank))) begin
          vic_f <= 1'b1;
        end
        if (!ent_valid && !free_f) begin
          free_f <= 1'b1;
        end
      end

      // The pending promote is now written back; retire sets the next one.
      if (scan_last && state == lrupin_pkg::ST_SCAN) begin
        pend_v <= 1'b0;
      end

      if (load) begin
        pend_v <= do_store;
        if (do_store && !hit_f && !full) begin
          valid[store_idx] <= 1'b1;
          count            <= count + CNT_W'(1);
        end
        if (do_store && own_ok) begin
          own_v[req_q.assigned_channel[OWN_W-1:0]] <= 1'b1;
        end
      end

      if (load) begin
        rsp_valid <= 1'b1;
      end else if (taken) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (rd_en) begin
      eval_idx <= scan_cnt[IDX_W-1:0];
    end
    if (eval_vld) begin
      if (ent_valid && (ent_key == req_q.sound_key) && !hit_f) begin
        hit_idx  <= eval_idx;
        hit_rank <= ent_rank;
      end
      if (ent_valid && !ent_pinned && (!vic_f || (ent_rank > vic_rank))) begin
        vic_idx  <= eval_idx;
        vic_rank <= ent_rank;
        vic_key  <= ent_key;
      end
      if (!ent_valid && !free_f) begin
        free_idx <= eval_idx;
      end
    end
    if (load) begin
      rsp         <= rsp_next;
      pend_slot   <= store_idx;
      pend_below  <= store_below;
      pend_key    <= req_q.sound_key;
      if (do_store && own_ok) begin
        own_k[req_q.assigned_channel[OWN_W-1:0]] <= req_q.sound_key;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(valid))
    else $error("entry count differs from number of valid entries");

  a_hit_exclusive: assert property (@(posedge clk) disable iff (rst)
    load && hit_f |=> rsp_valid && !rsp.evicted && !rsp.no_victim)
    else $error("hit response also flags eviction or no victim");

  a_write_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == lrupin_pkg::ST_SCAN)
    else $error("memory written outside a scan");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lrupin_pkg::ST_SCAN && scan_cnt == '0)
    else $error("accepted item did not start a scan");

  a_no_victim_nothing_stored: assert property (@(posedge clk) disable iff (rst)
    load && rsp_next.no_victim |=> !pend_v && $stable(count))
    else $error("state changed on a no-victim response");

endmodule

`default_nettype wire

@@ hw/rtl/lrupin_ram.sv @@
// ----------------------------------------------------------------------------
// lrupin_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
